// ===== rtl/sixteen_bit_cpu_execute_core_macros.svh =====
// Assertion macros for the execute core. SYNTH drops them.
`ifndef SIXTEEN_BIT_CPU_EXECUTE_CORE_MACROS_SVH
`define SIXTEEN_BIT_CPU_EXECUTE_CORE_MACROS_SVH

`ifndef SYNTH

`define SBCE_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sbce assertion failed (same cycle)");

`define SBCE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sbce assertion failed (next cycle)");

`else

`define SBCE_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define SBCE_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ===== rtl/sbce_pkg.sv =====
`default_nettype none

package sbce_pkg;

   localparam int WORD_W    = 16;
   localparam int FLAG_W    = 4;
   localparam int REG_AW    = 4;
   localparam int REG_COUNT = 16;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_V = 2;
   localparam int FLAG_N = 3;

   localparam logic [3:0]  COND_ALWAYS = 4'd0;
   localparam logic [3:0]  COND_GT     = 4'd1;
   localparam logic [3:0]  COND_NEG    = 4'd2;
   localparam logic [3:0]  COND_NZ     = 4'd3;
   localparam logic [3:0]  COND_ZERO   = 4'd4;
   localparam logic [3:0]  COND_CARRY  = 4'd5;
   localparam logic [3:0]  COND_OVF    = 4'd6;

   localparam logic [7:0]  SHIFT_MAX         = 8'd8;
   localparam logic [15:0] STACK_START_RESET = 16'd16383;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [FLAG_W-1:0] flags_type;
   typedef logic [REG_AW-1:0] reg_addr_type;

   typedef enum logic [3:0] {
      OP_ADDI  = 4'h0,
      OP_BRDNZ = 4'h1,
      OP_SET   = 4'h2,
      OP_LDR   = 4'h3,
      OP_LDI   = 4'h4,
      OP_STR   = 4'h5,
      OP_SH    = 4'h6,
      OP_ADD   = 4'h7,
      OP_BR    = 4'h8,
      OP_JMP   = 4'h9,
      OP_SUBI  = 4'hA,
      OP_SUB   = 4'hB,
      OP_XOR   = 4'hC,
      OP_AND   = 4'hD,
      OP_OR    = 4'hE,
      OP_CALL  = 4'hF
   } opcode_type;

   typedef enum logic [1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_SHIFT  = 2'd1,
      FAULT_TARGET = 2'd2,
      FAULT_ADDR   = 2'd3
   } fault_type;

   // Everything one instruction does, as decided in the execute stage.
   typedef struct packed {
      word_type     next_pc;
      word_type     sp;
      word_type     dest_value;
      flags_type    flags;
      logic         taken;
      fault_type    fault;
      logic         rf_we;
      reg_addr_type rf_waddr;
      word_type     rf_wdata;
      logic         mem_we;
      word_type     mem_addr;   // word address, before wrap to memory depth
      word_type     mem_wdata;
      logic         load;       // result waits for the memory read
   } exec_result_type;

   function automatic flags_type zn_flags(input word_type r);
      flags_type f;
      f         = '0;
      f[FLAG_Z] = (r == '0);
      f[FLAG_N] = r[WORD_W-1];
      return f;
   endfunction

   function automatic flags_type add_flags(input word_type a, input word_type b,
                                           input word_type r);
      word_type  mx;
      flags_type f;
      mx        = (a > b) ? a : b;
      f         = zn_flags(r);
      f[FLAG_C] = (r < mx);
      f[FLAG_V] = (a[WORD_W-1] == b[WORD_W-1]) && (r[WORD_W-1] != a[WORD_W-1]);
      return f;
   endfunction

   function automatic flags_type sub_flags(input word_type a, input word_type b,
                                           input word_type r);
      word_type  nb;
      word_type  mn;
      flags_type f;
      nb        = word_type'(16'd0 - b);
      mn        = (a < nb) ? a : nb;
      f         = zn_flags(r);
      f[FLAG_C] = (r > mn);
      f[FLAG_V] = (a[WORD_W-1] == nb[WORD_W-1]) && (r[WORD_W-1] != a[WORD_W-1]);
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sixteen_bit_cpu_execute_core.sv =====
// Execute core of a small 16-bit processor. Fetch is external.
// req_* channel: one instruction word per transaction, executed as if it sat at the
//   current program counter.
// rsp_* channel: one result per instruction: next word address to fetch, stack
//   pointer, destination register value, flags, branch-taken and fault code.
// csr_*: writing loads the stack pointer at once; write only while idle.
// Flow: an accepted instruction sits in the execute stage, then its result is registered;
//   loads (ldr) go through the load completion stage for the synchronous data memory read.
// Throughput: one instruction per cycle while rsp_tready does not stall the output; a load
//   holds off the next instruction, because its destination register waits on the data
//   memory read port before the next instruction may read its operands.
// Reset: registers, flags and program counter clear, stack pointer takes 16383.
//   Data memory contents are undefined until written.
// When rsp_tready is low the result holds in the output register, one more
//   instruction waits in the execute stage, and then req_tready drops.
`default_nettype none

module sixteen_bit_cpu_execute_core #(
   parameter int MEM_ADDR_W = 12      // data memory holds 2**MEM_ADDR_W words
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] instruction
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,    // [15:0] next_pc, [31:16] stack_pointer_out,
                                          // [47:32] dest_value, [51:48] flag_view,
                                          // [52] branch_taken, [54:53] fault_code
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   import sbce_pkg::*;

`include "sixteen_bit_cpu_execute_core_macros.svh"

   // architectural state
   word_type     pc_ff,    pc_in;
   word_type     sp_ff,    sp_in;
   flags_type    flags_ff, flags_in;

   // execute stage
   logic         e_valid_ff, e_valid_in;
   word_type     e_instr_ff, e_instr_in;

   // load completion stage
   logic         m_valid_ff, m_valid_in;
   word_type     m_next_pc_ff;
   word_type     m_sp_ff;
   flags_type    m_flags_ff;
   reg_addr_type m_ra_ff;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [55:0]  rsp_data_ff,  rsp_data_in;

   word_type        op_a;
   word_type        op_b;
   word_type        mem_rdata;
   exec_result_type ex;

   logic         accept;
   logic         out_free;
   logic         e_fire;
   logic         m_fire;
   logic         rf_we;
   reg_addr_type rf_waddr;
   word_type     rf_wdata;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign e_fire   = e_valid_ff && !m_valid_ff && (ex.load || out_free);
   assign m_fire   = m_valid_ff && out_free;

   assign req_tready = (!e_valid_ff || (e_fire && !ex.load)) && (!m_valid_ff || m_fire);
   assign accept     = req_tvalid && req_tready;

   // one register write per cycle: a finishing load or the execute stage
   assign rf_we    = m_fire || (e_fire && ex.rf_we);
   assign rf_waddr = m_valid_ff ? m_ra_ff : ex.rf_waddr;
   assign rf_wdata = m_valid_ff ? mem_rdata : ex.rf_wdata;

   sbce_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_tdata[11:8]),
      .rd_addr_b (req_tdata[7:4]),
      .wr_en     (rf_we),
      .wr_addr   (rf_waddr),
      .wr_data   (rf_wdata),
      .rd_data_a (op_a),
      .rd_data_b (op_b)
   );

   sbce_alu u_alu (
      .instr (e_instr_ff),
      .a     (op_a),
      .b     (op_b),
      .pc    (pc_ff),
      .sp    (sp_ff),
      .flags (flags_ff),
      .ex    (ex)
   );

   sbce_dmem #(
      .ADDR_W (MEM_ADDR_W)
   ) u_dmem (
      .clock   (clock),
      .wr_en   (e_fire && ex.mem_we),
      .wr_addr (ex.mem_addr[MEM_ADDR_W-1:0]),
      .wr_data (ex.mem_wdata),
      .rd_en   (e_fire && ex.load),
      .rd_addr (ex.mem_addr[MEM_ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   always_comb begin
      pc_in    = pc_ff;
      sp_in    = sp_ff;
      flags_in = flags_ff;
      if (e_fire) begin
         pc_in    = ex.next_pc;
         sp_in    = ex.sp;
         flags_in = ex.flags;
      end
      if (csr_we) begin
         sp_in = csr_wdata;
      end
   end

   always_comb begin
      e_instr_in = e_instr_ff;
      e_valid_in = e_valid_ff;
      if (e_fire) begin
         e_valid_in = 1'b0;
      end
      if (accept) begin
         e_valid_in = 1'b1;
         e_instr_in = req_tdata;
      end
      m_valid_in = m_valid_ff;
      if (m_fire) begin
         m_valid_in = 1'b0;
      end
      if (e_fire && ex.load) begin
         m_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = m_fire || (e_fire && !ex.load);
         if (m_fire) begin
            rsp_data_in = {1'b0, FAULT_NONE, 1'b0, m_flags_ff, mem_rdata,
                           m_sp_ff, m_next_pc_ff};
         end else begin
            rsp_data_in = {1'b0, ex.fault, ex.taken, ex.flags, ex.dest_value,
                           ex.sp, ex.next_pc};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         sp_ff        <= STACK_START_RESET;
         flags_ff     <= '0;
         e_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         flags_ff     <= flags_in;
         e_valid_ff   <= e_valid_in;
         m_valid_ff   <= m_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_instr_ff  <= e_instr_in;
      rsp_data_ff <= rsp_data_in;
      if (e_fire && ex.load) begin
         m_next_pc_ff <= ex.next_pc;
         m_sp_ff      <= ex.sp;
         m_flags_ff   <= ex.flags;
         m_ra_ff      <= ex.rf_waddr;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SBCE_ASSERT_IMPLIES(a_stage_excl, clock, reset, m_valid_ff, !e_valid_ff)
   `SBCE_ASSERT_NEXT(a_load_waits, clock, reset, e_fire && ex.load, m_valid_ff && !e_valid_ff)
   `SBCE_ASSERT_NEXT(a_fault_pc_kept, clock, reset, e_fire && (ex.fault != FAULT_NONE),
                     pc_ff == $past(pc_ff))
   `SBCE_ASSERT_IMPLIES(a_fault_no_effect, clock, reset, e_valid_ff && (ex.fault != FAULT_NONE),
                        !ex.rf_we && !ex.mem_we && !ex.taken && !ex.load)

endmodule

`default_nettype wire

// ===== rtl/sbce_regfile.sv =====
`default_nettype none

module sbce_regfile (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire sbce_pkg::reg_addr_type rd_addr_a,
   input  wire sbce_pkg::reg_addr_type rd_addr_b,
   input  wire logic                  wr_en,
   input  wire sbce_pkg::reg_addr_type wr_addr,
   input  wire sbce_pkg::word_type     wr_data,
   output sbce_pkg::word_type          rd_data_a,
   output sbce_pkg::word_type          rd_data_b
);
   import sbce_pkg::*;

   word_type regs_ff [REG_COUNT];
   word_type rd_a_ff;
   word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr_en) begin
         regs_ff[wr_addr] <= wr_data;
      end
   end

   // operands are captured at accept; a write in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : regs_ff[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : regs_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/sbce_dmem.sv =====
`default_nettype none

module sbce_dmem #(
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire sbce_pkg::word_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output sbce_pkg::word_type     rd_data
);
   import sbce_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   word_type ram_ff [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sbce_alu.sv =====
`default_nettype none

module sbce_alu (
   input  wire sbce_pkg::word_type   instr,
   input  wire sbce_pkg::word_type   a,
   input  wire sbce_pkg::word_type   b,
   input  wire sbce_pkg::word_type   pc,
   input  wire sbce_pkg::word_type   sp,
   input  wire sbce_pkg::flags_type  flags,
   output sbce_pkg::exec_result_type ex
);
   import sbce_pkg::*;

   opcode_type   op;
   reg_addr_type ra;
   reg_addr_type rc;
   logic [7:0]   imm;
   logic         x_bit;
   word_type     imm16;
   word_type     pc_inc;
   word_type     br_sum;
   word_type     br_target;
   logic [7:0]   shift_mag;
   logic         cond_ok;
   word_type     r;

   assign op        = opcode_type'(instr[15:12]);
   assign ra        = instr[11:8];
   assign rc        = instr[3:0];
   assign imm       = instr[7:0];
   assign x_bit     = instr[0];
   assign imm16     = {8'h00, imm};
   assign pc_inc    = pc + 16'd1;
   assign br_sum    = pc + {{8{imm[7]}}, imm};
   assign br_target = {1'b0, br_sum[14:0]};    // byte address is 16 bits
   assign shift_mag = imm[7] ? (8'd0 - imm) : imm;

   always_comb begin
      case (ra)
         COND_ALWAYS: cond_ok = 1'b1;
         COND_GT:     cond_ok = !flags[FLAG_N] && !flags[FLAG_Z];
         COND_NEG:    cond_ok = flags[FLAG_N];
         COND_NZ:     cond_ok = !flags[FLAG_Z];
         COND_ZERO:   cond_ok = flags[FLAG_Z];
         COND_CARRY:  cond_ok = flags[FLAG_C];
         COND_OVF:    cond_ok = flags[FLAG_V];
         default:     cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      r            = '0;
      ex.next_pc   = pc_inc;
      ex.sp        = sp;
      ex.dest_value = '0;
      ex.flags     = flags;
      ex.taken     = 1'b0;
      ex.fault     = FAULT_NONE;
      ex.rf_we     = 1'b0;
      ex.rf_waddr  = ra;
      ex.rf_wdata  = '0;
      ex.mem_we    = 1'b0;
      ex.mem_addr  = {1'b0, b[15:1]};
      ex.mem_wdata = a;
      ex.load      = 1'b0;

      case (op)
         OP_ADDI: begin
            r = a + imm16;
            ex.flags = add_flags(a, imm16, r);
            ex.rf_we = 1'b1;
         end
         OP_SUBI: begin
            r = a - imm16;
            ex.flags = sub_flags(a, imm16, r);
            ex.rf_we = 1'b1;
         end
         OP_ADD: begin
            r = a + b;
            ex.flags    = add_flags(a, b, r);
            ex.rf_we    = 1'b1;
            ex.rf_waddr = rc;
         end
         OP_SUB: begin
            r = a - b;
            ex.flags    = sub_flags(a, b, r);
            ex.rf_we    = 1'b1;
            ex.rf_waddr = rc;
         end
         OP_XOR, OP_AND, OP_OR: begin
            if (op == OP_XOR) begin
               r = a ^ b;
            end else if (op == OP_AND) begin
               r = a & b;
            end else begin
               r = a | b;
            end
            ex.flags    = zn_flags(r);
            ex.rf_we    = 1'b1;
            ex.rf_waddr = rc;
         end
         OP_SH: begin
            if (shift_mag > SHIFT_MAX) begin
               ex.fault = FAULT_SHIFT;
               r = a;
            end else begin
               r = imm[7] ? (a << shift_mag[3:0]) : (a >> shift_mag[3:0]);
               ex.flags = zn_flags(r);
               ex.rf_we = 1'b1;
            end
         end
         OP_SET: begin
            r = x_bit ? (16'd0 - b) : b;
            ex.rf_we = 1'b1;
         end
         OP_BR: begin
            if (cond_ok) begin
               ex.next_pc = br_target;
               ex.taken   = 1'b1;
            end
         end
         OP_BRDNZ: begin
            r = a;
            if (a != '0) begin
               r = a - 16'd1;
               ex.rf_we   = 1'b1;
               ex.next_pc = br_target;
               ex.taken   = 1'b1;
            end
         end
         OP_CALL, OP_JMP: begin
            if (a[0]) begin
               ex.fault = FAULT_TARGET;
            end else begin
               ex.next_pc = {1'b0, a[15:1]};
               ex.taken   = 1'b1;
               if (op == OP_CALL) begin
                  // push the byte return address
                  ex.mem_we    = 1'b1;
                  ex.mem_addr  = sp;
                  ex.mem_wdata = {pc_inc[14:0], 1'b0};
                  ex.sp        = sp + 16'd1;
               end
            end
         end
         OP_LDI: begin
            r = {a[15:8], imm};
            ex.rf_we = 1'b1;
         end
         OP_STR: begin
            if (x_bit) begin
               ex.mem_we   = 1'b1;
               ex.mem_addr = sp;
               ex.sp       = sp + 16'd1;
            end else if (b[0]) begin
               ex.fault = FAULT_ADDR;
            end else begin
               ex.mem_we = 1'b1;
            end
         end
         OP_LDR: begin
            r = a;
            if (x_bit) begin
               ex.sp       = sp - 16'd1;
               ex.mem_addr = sp - 16'd1;
               ex.load     = 1'b1;
            end else if (b[0]) begin
               ex.fault = FAULT_ADDR;
            end else begin
               ex.load = 1'b1;
            end
         end
         default: begin
            r = '0;
         end
      endcase

      ex.rf_wdata = r;
      // instructions without a destination register report zero
      if ((op == OP_BR) || (op == OP_CALL) || (op == OP_JMP) || (op == OP_STR)) begin
         ex.dest_value = '0;
      end else begin
         ex.dest_value = r;
      end

      if (ex.fault != FAULT_NONE) begin
         ex.next_pc = pc;
         ex.taken   = 1'b0;
      end
   end

endmodule

`default_nettype wire
